// ===== src/slc_pkg.sv =====
`default_nettype none

package slc_pkg;

    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 10;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef logic [VALUE_BITS-1:0] t_value;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic   shift_in;   // insert: place value, shift entries at or above it right
        logic   shift_out;  // drain: every cell takes its right neighbor
        t_value value;      // value being inserted
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== src/slc_cell.sv =====
`default_nettype none

module slc_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  slc_pkg::t_cell_ctrl  i_ctrl,
    input  slc_pkg::t_value      i_left_value,
    input  wire                  i_left_valid,
    input  wire                  i_left_ge,
    input  slc_pkg::t_value      i_right_value,
    input  wire                  i_right_valid,
    output slc_pkg::t_value      o_value,
    output logic                 o_valid,
    output logic                 o_ge
);

    slc_pkg::t_value r_value;
    slc_pkg::t_value n_value;
    logic            r_valid;
    logic            n_valid;

    // An empty cell counts as holding a value at or above anything inserted.
    assign o_ge    = !r_valid || (r_value >= i_ctrl.value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.shift_out) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctrl.shift_in) begin
            if (i_left_ge) begin
                // insertion point lies to the left: take the neighbor's entry
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else if (o_ge) begin
                n_value = i_ctrl.value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

// ===== src/sorted_insertion_list_top.sv =====
// Channel   Handshake           Payload                                   Direction
// -------   -----------------   ---------------------------------------   ---------
// command   start / busy        i_cmd, i_value                            in
// result    o_strobe (1 cycle)  o_sorted_value, o_last, o_empty_res,      out
//                               o_overflowed
//
// An insert never raises busy; inserts may follow back to back, start held high.
// A drain of N stored values raises busy once it is accepted and keeps it high
// while the cell chain shifts its values out one by one; the last one drops busy.
// A drain of an empty store gives its single result in the next cycle, no busy.
// Reset (i_rst_n low at a clock edge) empties the chain and clears the flag.
// Results cannot be stalled: each strobe is a transaction taken as it appears.
`default_nettype none

module sorted_insertion_list_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire                     i_cmd,
    input  wire  [slc_pkg::VALUE_BITS-1:0] i_value,
    output logic                    o_strobe,
    output logic [slc_pkg::VALUE_BITS-1:0] o_sorted_value,
    output logic                    o_last,
    output logic                    o_empty_res,
    output logic                    o_overflowed
);

    localparam int N = slc_pkg::CAPACITY;

    // Chain wiring: one entry per cell.
    slc_pkg::t_value     w_value [N];
    logic [N-1:0]        w_valid;
    logic [N-1:0]        w_ge;
    slc_pkg::t_cell_ctrl w_ctrl;

    // Control state.
    logic r_draining;
    logic n_draining;
    logic r_ovf_flag;
    logic n_ovf_flag;
    logic r_ovf_snap;
    logic n_ovf_snap;

    // Result registers.
    logic            r_strobe;
    logic            n_strobe;
    slc_pkg::t_value r_res_value;
    slc_pkg::t_value n_res_value;
    logic            r_res_last;
    logic            n_res_last;
    logic            r_res_empty;
    logic            n_res_empty;
    logic            r_res_ovf;
    logic            n_res_ovf;

    logic accept;
    logic is_drain;
    logic full;

    assign accept   = start && !busy;
    assign is_drain = (i_cmd == slc_pkg::CMD_DRAIN);
    // Cells fill from the left, so the last cell is valid only when full.
    assign full     = w_valid[N-1];
    assign busy     = r_draining;

    // Broadcast one control word to the whole chain.
    assign w_ctrl.shift_in  = accept && !is_drain && !full;
    assign w_ctrl.shift_out = r_draining;
    assign w_ctrl.value     = i_value;

    // Row of compare-and-shift cells. Cell 0 is the smallest entry; an insert
    // lands at the first cell whose entry is at or above the value (or empty),
    // and every cell to its right takes its left neighbor's entry. A drain
    // pulls every entry one cell to the left per cycle.
    for (genvar g = 0; g < N; g++) begin : g_cell
        slc_pkg::t_value left_value;
        logic            left_valid;
        logic            left_ge;
        slc_pkg::t_value right_value;
        logic            right_valid;

        if (g == 0) begin : g_head
            assign left_value = '0;
            assign left_valid = 1'b0;
            assign left_ge    = 1'b0;
        end else begin : g_mid_l
            assign left_value = w_value[g-1];
            assign left_valid = w_valid[g-1];
            assign left_ge    = w_ge[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid_r
            assign right_value = w_value[g+1];
            assign right_valid = w_valid[g+1];
        end

        slc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left_value  (left_value),
            .i_left_valid  (left_valid),
            .i_left_ge     (left_ge),
            .i_right_value (right_value),
            .i_right_valid (right_valid),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_ge          (w_ge[g])
        );
    end

    always_comb begin
        n_draining  = r_draining;
        n_ovf_flag  = r_ovf_flag;
        n_ovf_snap  = r_ovf_snap;
        n_strobe    = 1'b0;
        n_res_value = r_res_value;
        n_res_last  = r_res_last;
        n_res_empty = r_res_empty;
        n_res_ovf   = r_res_ovf;

        if (r_draining) begin
            // Emit the head cell; the chain shifts left in the same edge.
            n_strobe    = 1'b1;
            n_res_value = w_value[0];
            n_res_last  = (N > 1) ? !w_valid[1 % N] : 1'b1;
            n_res_empty = 1'b0;
            n_res_ovf   = r_ovf_snap;
            if (n_res_last) begin
                n_draining = 1'b0;
            end
        end else if (accept) begin
            if (is_drain) begin
                // Snapshot and clear the sticky flag for this drain.
                n_ovf_flag = 1'b0;
                if (!w_valid[0]) begin
                    n_strobe    = 1'b1;
                    n_res_value = '0;
                    n_res_last  = 1'b1;
                    n_res_empty = 1'b1;
                    n_res_ovf   = r_ovf_flag;
                end else begin
                    n_draining = 1'b1;
                    n_ovf_snap = r_ovf_flag;
                end
            end else if (full) begin
                // Drop the value and remember that a drop happened.
                n_ovf_flag = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_ovf_flag <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_draining <= n_draining;
            r_ovf_flag <= n_ovf_flag;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf_snap  <= n_ovf_snap;
        r_res_value <= n_res_value;
        r_res_last  <= n_res_last;
        r_res_empty <= n_res_empty;
        r_res_ovf   <= n_res_ovf;
    end

    assign o_strobe       = r_strobe;
    assign o_sorted_value = r_res_value;
    assign o_last         = r_res_last;
    assign o_empty_res    = r_res_empty;
    assign o_overflowed   = r_res_ovf;

endmodule

`default_nettype wire

// ===== src/slc_checker.sv =====
`default_nettype none

module slc_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            start,
    input wire                            busy,
    input wire                            i_cmd,
    input wire                            o_strobe,
    input wire [slc_pkg::VALUE_BITS-1:0]  o_sorted_value,
    input wire                            o_last,
    input wire                            o_empty_res,
    input wire                            o_overflowed
);

    // A drain result that is not the last keeps the block busy; the last frees it.
    a_busy_through_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy == !o_last))
        else $error("busy does not track drain progress");

    // An empty drain gives one zero-valued, final result.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_empty_res) |-> (o_last && (o_sorted_value == '0)))
        else $error("empty result malformed");

    // An accepted drain either answers at once (empty) or goes busy.
    a_drain_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == slc_pkg::CMD_DRAIN)) |=> (o_strobe || busy))
        else $error("drain produced no response");

    // Within one drain, results follow without gaps and carry one overflow mark.
    a_drain_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_strobe && !o_empty_res && $stable(o_overflowed)))
        else $error("drain results broken or overflow mark changed");

endmodule

bind sorted_insertion_list_top slc_checker u_slc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_strobe       (o_strobe),
    .o_sorted_value (o_sorted_value),
    .o_last         (o_last),
    .o_empty_res    (o_empty_res),
    .o_overflowed   (o_overflowed)
);

`default_nettype wire

// ===== test/sorted_insertion_list_top_tb.sv =====
`default_nettype none

// One result transaction as the block puts it on its output ports.
typedef struct packed {
    slc_pkg::t_value sorted_value;
    logic            last;
    logic            empty_res;
    logic            overflowed;
} t_sorted_beat;

// Tracks the sorted contents the block should hold and queues the drain
// transactions that each accepted command implies.
class sorted_list_scoreboard;
    slc_pkg::t_value held[$];        // ascending copy of the cell chain
    bit              overflow_seen;  // sticky drop flag since the last drain
    t_sorted_beat    drain_beats[$]; // drain results not yet seen on the outputs
    int errors;
    int inserts;
    int dropped;
    int drains;
    int full_drains;
    int empty_drains;
    int beats_checked;

    function void note_command(logic cmd, slc_pkg::t_value v);
        int pos;
        t_sorted_beat beat;
        if (cmd == slc_pkg::CMD_INSERT) begin
            inserts++;
            if (held.size() >= slc_pkg::CAPACITY) begin
                overflow_seen = 1'b1;
                dropped++;
            end else begin
                // Go past strictly smaller values only, so a new value goes ahead of equal ones, as in the chain.
                pos = 0;
                while (pos < held.size() && held[pos] < v)
                    pos++;
                held.insert(pos, v);
            end
        end else begin
            drains++;
            if (held.size() == 0) begin
                empty_drains++;
                beat.sorted_value = '0;
                beat.last         = 1'b1;
                beat.empty_res    = 1'b1;
                beat.overflowed   = overflow_seen;
                drain_beats.push_back(beat);
            end else begin
                if (held.size() == slc_pkg::CAPACITY)
                    full_drains++;
                foreach (held[k]) begin
                    beat.sorted_value = held[k];
                    beat.last         = (k == held.size() - 1);
                    beat.empty_res    = 1'b0;
                    beat.overflowed   = overflow_seen;
                    drain_beats.push_back(beat);
                end
            end
            held.delete();
            overflow_seen = 1'b0;
        end
    endfunction

    function string beat_text(t_sorted_beat b);
        return $sformatf("value=%0d last=%0b empty=%0b ovf=%0b",
                         b.sorted_value, b.last, b.empty_res, b.overflowed);
    endfunction

    function void check_result(t_sorted_beat got);
        t_sorted_beat want;
        if (drain_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %s", $time, beat_text(got));
        end else begin
            want = drain_beats.pop_front();
            beats_checked++;
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch expected %s, actual %s",
                         $time, beat_text(want), beat_text(got));
            end
        end
    endfunction

    function int pending();
        return drain_beats.size();
    endfunction
endclass

module sorted_insertion_list_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_ITEMS = 460;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    logic            i_cmd   = slc_pkg::CMD_INSERT;
    slc_pkg::t_value i_value = '0;

    logic            busy;
    logic            o_strobe;
    slc_pkg::t_value o_sorted_value;
    logic            o_last;
    logic            o_empty_res;
    logic            o_overflowed;

    sorted_list_scoreboard sb = new();

    int  items_sent;
    bit  steady;    // when set, hold start high with no gaps for the whole burst

    sorted_insertion_list_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last         (o_last),
        .o_empty_res    (o_empty_res),
        .o_overflowed   (o_overflowed)
    );

    always #10 i_clk = ~i_clk;

    // Sample at the rising edge, before any nonblocking update lands, so both
    // the result strobe and the start/busy handshake are seen as they stood in
    // the cycle that this edge ends. Check results first: a strobe at this edge
    // always belongs to a command accepted at an earlier edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_result({o_sorted_value, o_last, o_empty_res, o_overflowed});
            if (start && !busy)
                sb.note_command(i_cmd, i_value);
        end
    end

    // Mostly back to back, often a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Lean on the extremes and a coarse grid so duplicates show up often.
    function automatic slc_pkg::t_value pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        if (r < 40)
            return slc_pkg::t_value'($urandom_range(0, 7) * 146);
        return slc_pkg::t_value'($urandom_range(0, (1 << slc_pkg::VALUE_BITS) - 1));
    endfunction

    // Present one command and hold it until the block takes it. On return the
    // current time step is the edge that accepted the transaction.
    task automatic send_command(input logic cmd, input slc_pkg::t_value v, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic insert_value(input slc_pkg::t_value v);
        send_command(slc_pkg::CMD_INSERT, v, pick_gap());
    endtask

    // The value port is don't-care on a drain: drive noise on it anyway.
    task automatic drain_store();
        send_command(slc_pkg::CMD_DRAIN, slc_pkg::t_value'($urandom()), pick_gap());
    endtask

    // One well-formed sequence: a run of inserts, then a drain. Most runs are
    // short; a share fills the chain exactly or pushes past it to drop values.
    task automatic run_burst();
        int r;
        int count;
        r      = $urandom_range(0, 99);
        steady = ($urandom_range(0, 99) < 30);
        if (r < 60)
            count = $urandom_range(1, 12);
        else if (r < 75)
            count = $urandom_range(13, slc_pkg::CAPACITY - 1);
        else if (r < 88)
            count = slc_pkg::CAPACITY;
        else
            count = $urandom_range(slc_pkg::CAPACITY + 1, slc_pkg::CAPACITY + 8);
        repeat (count) insert_value(pick_value());
        drain_store();
        // Occasionally drain again right away to hit the empty store.
        if ($urandom_range(0, 99) < 10)
            drain_store();
    endtask

    initial begin
        // Hold reset low, then release it on a clock edge.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty drain straight out of reset.
        drain_store();
        // Extremes, a duplicate pair, alternating bit patterns, reverse order.
        insert_value(10'd1023);
        insert_value(10'd0);
        insert_value(10'd5);
        insert_value(10'd5);
        insert_value(10'h2AA);
        insert_value(10'h155);
        insert_value(10'd1);
        insert_value(10'd1022);
        drain_store();
        // Store is clear now: a second drain must report empty.
        drain_store();
        // Single entry: one result, marked last, not empty.
        insert_value(10'd0);
        drain_store();
        insert_value(10'd1023);
        insert_value(10'd1023);
        drain_store();

        // Random: sequences of inserts closed by a drain, with gaps on the sender.
        while (items_sent < TARGET_ITEMS)
            run_burst();

        // Drop start at the edge that accepted the final transaction.
        steady = 1'b0;
        start <= 1'b0;

        // Wait for every drain to finish, then keep clocking before the summary.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (slc_pkg::CAPACITY + 8) @(posedge i_clk);

        $display("covered %0d inserts (%0d dropped), %0d drains (%0d full, %0d empty)",
                 sb.inserts, sb.dropped, sb.drains, sb.full_drains, sb.empty_drains);
        $display("checked %0d result transactions, %0d errors", sb.beats_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sorted_insertion_list_top_tb OK");
        end else begin
            $display("sorted_insertion_list_top_tb NOT OK");
        end
        $finish;
    end

    // Stop a hung run well past the slowest correct one.
    initial begin
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
        $display("sorted_insertion_list_top_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
